// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file pfe_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pfe_pkg.sv =====
// Package: types, widths and codes of the polyline field engine.
`default_nettype none
package pfe_pkg;
	localparam int MAX_POINTS_DEF = 1024;

	localparam int CMD_W   = 2;
	localparam int COORD_W = 16;
	localparam int GAIN_W  = 16;
	localparam int FIELD_W = 32;
	localparam int COUNT_W = 11;
	localparam int STAT_W  = 2;

	localparam int VTX_W   = 3 * COORD_W;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int CROSS_W = 2 * DIFF_W + 1;
	localparam int R2_W    = 2 * DIFF_W;
	localparam int ROOT_W  = R2_W / 2;
	localparam int DEN_W   = R2_W + ROOT_W;
	localparam int NUM_W   = GAIN_W + CROSS_W;
	localparam int FRAC_W  = 16;

	localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd2560;
	localparam logic [FIELD_W-1:0] FIELD_MAX  = 32'h7FFF_FFFF;
	localparam logic [FIELD_W-1:0] FIELD_MIN  = 32'h8000_0000;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_ZERO  = 2'd3
	} stat_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} vtx_t;

	// Exact difference of two signed Q8.8 coordinates.
	function automatic logic signed [DIFF_W-1:0] sub_coord(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
	endfunction
endpackage
`default_nettype wire

// ===== hdl/polyline_wire_field_engine.sv =====
// Top level: vertex store, segment sequencer and field accumulation.
// Append, remove, undefined command and a query over fewer than two vertices: result
// in the cycle after start; a new start is taken in the cycle the result appears.
// Query: busy while each segment runs through the square root and the dividers; a
// segment whose start coincides with the query point skips both. The result comes in the same cycle that busy falls.
// Reset clears the vertex count and the control state and sets the gain to 10.0.
`default_nettype none
module polyline_wire_field_engine #(
	parameter int MAX_POINTS = pfe_pkg::MAX_POINTS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [pfe_pkg::CMD_W-1:0]          command,
	input  wire logic signed [pfe_pkg::COORD_W-1:0] coord_x,
	input  wire logic signed [pfe_pkg::COORD_W-1:0] coord_y,
	input  wire logic signed [pfe_pkg::COORD_W-1:0] coord_z,
	input  wire logic                               cfg_we,
	input  wire logic [pfe_pkg::GAIN_W-1:0]         cfg_wdata,
	output logic                                    done,
	output logic signed [pfe_pkg::FIELD_W-1:0]      field_x,
	output logic signed [pfe_pkg::FIELD_W-1:0]      field_y,
	output logic signed [pfe_pkg::FIELD_W-1:0]      field_z,
	output logic [pfe_pkg::COUNT_W-1:0]             vertex_count,
	output logic [pfe_pkg::STAT_W-1:0]              status,
	output logic                                    saturated
);
	import pfe_pkg::*;

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_LOAD   = 11'b000_0000_0010,
		ST_FETCH  = 11'b000_0000_0100,
		ST_DIFF   = 11'b000_0000_1000,
		ST_PROD   = 11'b000_0001_0000,
		ST_ROOT   = 11'b000_0010_0000,
		ST_SCALE  = 11'b000_0100_0000,
		ST_MAG    = 11'b000_1000_0000,
		ST_DSTART = 11'b001_0000_0000,
		ST_DIV    = 11'b010_0000_0000,
		ST_ACC    = 11'b100_0000_0000
	} state_t;

	function automatic logic [FIELD_W:0] contrib(input logic neg, input logic big,
			input logic [FIELD_W-1:0] q);
		logic [FIELD_W:0] r;
		if (big || q[FIELD_W-1]) begin
			// negative side clamps to the minimum without flagging
			r = neg ? {1'b0, FIELD_MIN} : {1'b1, FIELD_MAX};
		end else begin
			r = {1'b0, neg ? (-q) : q};
		end
		return r;
	endfunction

	function automatic logic [FIELD_W:0] sat_add(input logic [FIELD_W-1:0] a,
			input logic [FIELD_W-1:0] b);
		logic [FIELD_W:0] s;
		logic [FIELD_W:0] r;
		s = {a[FIELD_W-1], a} + {b[FIELD_W-1], b};
		if (s[FIELD_W] != s[FIELD_W-1]) begin
			r = {1'b1, s[FIELD_W] ? FIELD_MIN : FIELD_MAX};
		end else begin
			r = {1'b0, s[FIELD_W-1:0]};
		end
		return r;
	endfunction

	state_t state_q;

	logic [CNT_W-1:0]  count_q;
	logic [GAIN_W-1:0] gain_q;
	logic [AW-1:0]     seg_q;

	vtx_t qry_q;
	vtx_t prev_q;
	vtx_t rd_vtx;
	logic [VTX_W-1:0] rd_data;

	logic signed [DIFF_W-1:0]  dx_q, dy_q, dz_q, rx_q, ry_q, rz_q;
	logic signed [CROSS_W-1:0] cx_c, cy_c, cz_c, cx_q, cy_q, cz_q;
	logic [R2_W-1:0]           r2_c, r2_q;
	logic [DEN_W-1:0]          den_q;
	logic signed [NUM_W-1:0]   nx_q, ny_q, nz_q;
	logic [NUM_W-1:0]          magx_q, magy_q, magz_q;
	logic                      negx_q, negy_q, negz_q;

	logic [FIELD_W-1:0] fx_q, fy_q, fz_q;
	logic               sat_q;
	logic               zero_q;

	logic [FIELD_W-1:0] out_fx_q, out_fy_q, out_fz_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic [STAT_W-1:0]  out_stat_q;
	logic               out_sat_q;
	logic               done_q;

	logic               accept;
	logic               full;
	logic               ram_we;
	logic [AW-1:0]      raddr;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;
	logic [CNT_W:0]     seg_end;
	logic               last_seg;
	logic               fin;

	logic               sq_start, sq_done;
	logic [ROOT_W-1:0]  root;
	logic               dv_start, dv_done, dy_done, dz_done;
	logic               bigx, bigy, bigz;
	logic [FIELD_W-1:0] qx, qy, qz;

	logic [FIELD_W:0]   cvx, cvy, cvz, nfx, nfy, nfz;
	logic               acc_sat;

	assign accept  = start && (state_q == ST_IDLE);
	assign full    = count_q == CNT_W'(MAX_POINTS);
	assign ram_we  = accept && (command == CMD_APPEND) && !full;
	assign raddr   = (state_q == ST_IDLE) ? '0 : seg_q + AW'(1);
	assign rd_vtx  = vtx_t'(rd_data);
	assign cnt_ext = {{COUNT_W{1'b0}}, count_q};
	assign seg_end = (CNT_W + 1)'(seg_q) + (CNT_W + 1)'(2);
	assign last_seg = seg_end >= {1'b0, count_q};

	pfe_ram #(
		.WIDTH(VTX_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata({coord_x, coord_y, coord_z}),
		.raddr(raddr),
		.rdata(rd_data)
	);

	assign cx_c = CROSS_W'(dy_q * rz_q) - CROSS_W'(dz_q * ry_q);
	assign cy_c = CROSS_W'(rx_q * dz_q) - CROSS_W'(dx_q * rz_q);
	assign cz_c = CROSS_W'(dx_q * ry_q) - CROSS_W'(rx_q * dy_q);
	assign r2_c = $unsigned(R2_W'(rx_q * rx_q)) + $unsigned(R2_W'(ry_q * ry_q))
		+ $unsigned(R2_W'(rz_q * rz_q));

	// result strobe: accepted commands that start no query sequence, or the last segment of a query
	assign fin = (accept && !((command == CMD_QUERY) && (count_q >= CNT_W'(2))))
		|| ((state_q == ST_PROD) && (r2_c == '0) && last_seg)
		|| ((state_q == ST_ACC) && last_seg);

	assign sq_start = (state_q == ST_PROD) && (r2_c != '0);

	pfe_isqrt u_root (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.n     (r2_c),
		.done  (sq_done),
		.root  (root)
	);

	assign dv_start = state_q == ST_DSTART;

	pfe_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .mag(magx_q), .den(den_q),
		.done(dv_done), .big(bigx), .quo(qx)
	);
	pfe_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .mag(magy_q), .den(den_q),
		.done(dy_done), .big(bigy), .quo(qy)
	);
	pfe_div u_div_z (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .mag(magz_q), .den(den_q),
		.done(dz_done), .big(bigz), .quo(qz)
	);

	always_comb begin
		cvx = contrib(negx_q, bigx, qx);
		cvy = contrib(negy_q, bigy, qy);
		cvz = contrib(negz_q, bigz, qz);
		nfx = sat_add(fx_q, cvx[FIELD_W-1:0]);
		nfy = sat_add(fy_q, cvy[FIELD_W-1:0]);
		nfz = sat_add(fz_q, cvz[FIELD_W-1:0]);
		acc_sat = cvx[FIELD_W] | cvy[FIELD_W] | cvz[FIELD_W]
			| nfx[FIELD_W] | nfy[FIELD_W] | nfz[FIELD_W];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			gain_q  <= GAIN_RESET;
			seg_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			if (cfg_we) begin
				gain_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						seg_q <= '0;
						if (command == CMD_APPEND) begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else if (command == CMD_REMOVE) begin
							if (count_q != '0) begin
								count_q <= count_q - CNT_W'(1);
							end
						end else if ((command == CMD_QUERY) && (count_q >= CNT_W'(2))) begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD:   state_q <= ST_DIFF;
				ST_FETCH:  state_q <= ST_DIFF;
				ST_DIFF:   state_q <= ST_PROD;
				ST_PROD: begin
					if (r2_c != '0) begin
						state_q <= ST_ROOT;
					end else if (last_seg) begin
						state_q <= ST_IDLE;
					end else begin
						seg_q   <= seg_q + AW'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_ROOT: begin
					if (sq_done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE:  state_q <= ST_MAG;
				ST_MAG:    state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DIV;
				ST_DIV: begin
					if (dv_done && dy_done && dz_done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (last_seg) begin
						state_q <= ST_IDLE;
					end else begin
						seg_q   <= seg_q + AW'(1);
						state_q <= ST_FETCH;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				qry_q  <= {coord_x, coord_y, coord_z};
				fx_q   <= '0;
				fy_q   <= '0;
				fz_q   <= '0;
				sat_q  <= 1'b0;
				zero_q <= 1'b0;
				out_fx_q  <= '0;
				out_fy_q  <= '0;
				out_fz_q  <= '0;
				out_sat_q <= 1'b0;
				if (command == CMD_APPEND) begin
					out_cnt_q  <= full ? cnt_ext[COUNT_W-1:0]
						: COUNT_W'(cnt_ext + (CNT_W + COUNT_W)'(1));
					out_stat_q <= full ? STAT_FULL : STAT_OK;
				end else if (command == CMD_REMOVE) begin
					out_cnt_q  <= (count_q == '0) ? cnt_ext[COUNT_W-1:0]
						: COUNT_W'(cnt_ext - (CNT_W + COUNT_W)'(1));
					out_stat_q <= (count_q == '0) ? STAT_EMPTY : STAT_OK;
				end else begin
					out_cnt_q  <= cnt_ext[COUNT_W-1:0];
					out_stat_q <= STAT_OK;
				end
			end
			ST_LOAD: prev_q <= rd_vtx;
			ST_DIFF: begin
				dx_q <= sub_coord(rd_vtx.x, prev_q.x);
				dy_q <= sub_coord(rd_vtx.y, prev_q.y);
				dz_q <= sub_coord(rd_vtx.z, prev_q.z);
				rx_q <= sub_coord(qry_q.x, prev_q.x);
				ry_q <= sub_coord(qry_q.y, prev_q.y);
				rz_q <= sub_coord(qry_q.z, prev_q.z);
				prev_q <= rd_vtx;
			end
			ST_PROD: begin
				cx_q <= cx_c;
				cy_q <= cy_c;
				cz_q <= cz_c;
				r2_q <= r2_c;
				if (r2_c == '0) begin
					// coincident point: segment dropped, flagged in status
					zero_q <= 1'b1;
					if (last_seg) begin
						out_fx_q   <= fx_q;
						out_fy_q   <= fy_q;
						out_fz_q   <= fz_q;
						out_sat_q  <= sat_q;
						out_stat_q <= STAT_ZERO;
					end
				end
			end
			ST_SCALE: begin
				den_q <= DEN_W'(r2_q) * DEN_W'(root);
				nx_q  <= $signed({1'b0, gain_q}) * cx_q;
				ny_q  <= $signed({1'b0, gain_q}) * cy_q;
				nz_q  <= $signed({1'b0, gain_q}) * cz_q;
			end
			ST_MAG: begin
				negx_q <= nx_q[NUM_W-1];
				negy_q <= ny_q[NUM_W-1];
				negz_q <= nz_q[NUM_W-1];
				magx_q <= nx_q[NUM_W-1] ? $unsigned(-nx_q) : $unsigned(nx_q);
				magy_q <= ny_q[NUM_W-1] ? $unsigned(-ny_q) : $unsigned(ny_q);
				magz_q <= nz_q[NUM_W-1] ? $unsigned(-nz_q) : $unsigned(nz_q);
			end
			ST_ACC: begin
				fx_q  <= nfx[FIELD_W-1:0];
				fy_q  <= nfy[FIELD_W-1:0];
				fz_q  <= nfz[FIELD_W-1:0];
				sat_q <= sat_q | acc_sat;
				if (last_seg) begin
					out_fx_q   <= nfx[FIELD_W-1:0];
					out_fy_q   <= nfy[FIELD_W-1:0];
					out_fz_q   <= nfz[FIELD_W-1:0];
					out_sat_q  <= sat_q | acc_sat;
					out_stat_q <= zero_q ? STAT_ZERO : STAT_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = state_q != ST_IDLE;
	assign done         = done_q;
	assign field_x      = out_fx_q;
	assign field_y      = out_fy_q;
	assign field_z      = out_fz_q;
	assign vertex_count = out_cnt_q;
	assign status       = out_stat_q;
	assign saturated    = out_sat_q;
endmodule
`default_nettype wire

// ===== hdl/pfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module pfe_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/pfe_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module pfe_isqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [pfe_pkg::R2_W-1:0]     n,
	output logic                              done,
	output logic      [pfe_pkg::ROOT_W-1:0]   root
);
	import pfe_pkg::*;

	logic [R2_W-1:0] rem_q;
	logic [R2_W-1:0] res_q;
	logic [R2_W-1:0] bit_q;
	logic            run_q;
	logic            done_q;
	logic [R2_W:0]   trial;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && run_q && bit_q[0];
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= n;
			res_q <= '0;
			bit_q <= R2_W'(1) << (R2_W - 2);
		end else if (run_q) begin
			if ({1'b0, rem_q} >= trial) begin
				rem_q <= rem_q - trial[R2_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== hdl/pfe_div.sv =====
// Bit-serial divider: floor(mag * 2^16 / den), 32 quotient bits plus overflow flag.
`default_nettype none
module pfe_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pfe_pkg::NUM_W-1:0]     mag,
	input  wire logic [pfe_pkg::DEN_W-1:0]     den,
	output logic                               done,
	output logic                               big,
	output logic      [pfe_pkg::FIELD_W-1:0]   quo
);
	import pfe_pkg::*;

	localparam int CNT_W = $clog2(FIELD_W);
	localparam int EXT_W = DEN_W + FRAC_W;

	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic [FIELD_W-1:0] low_q;
	logic [FIELD_W-1:0] quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;
	logic               big_q;
	logic [DEN_W:0]     trial;
	logic               take;

	assign trial = {rem_q, low_q[FIELD_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(FIELD_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(FIELD_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient of 2^32 or more is clamped anyway
			big_q <= EXT_W'(mag) >= {den, FRAC_W'(0)};
			den_q <= den;
			rem_q <= DEN_W'(mag >> FRAC_W);
			low_q <= {mag[FRAC_W-1:0], (FIELD_W - FRAC_W)'(0)};
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			low_q <= low_q << 1;
			quo_q <= {quo_q[FIELD_W-2:0], take};
		end
	end

	assign done = done_q;
	assign big  = big_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ===== hdl/pfe_chk.sv =====
// Port-level checker for the polyline field engine, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module pfe_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               start,
	input wire logic                               busy,
	input wire logic [pfe_pkg::CMD_W-1:0]          command,
	input wire logic                               done,
	input wire logic signed [pfe_pkg::FIELD_W-1:0] field_x,
	input wire logic signed [pfe_pkg::FIELD_W-1:0] field_y,
	input wire logic signed [pfe_pkg::FIELD_W-1:0] field_z,
	input wire logic [pfe_pkg::STAT_W-1:0]         status,
	input wire logic                               saturated
);
	import pfe_pkg::*;

	// append, remove and undefined commands answer in the very next cycle
	`AST_NEXT(a_edit_latency, clk, arst_n, start && !busy && command != CMD_QUERY, done && !busy, "edit command did not complete in one cycle")
	`AST_IMPLY(a_done_idle, clk, arst_n, done, !busy, "result strobe while still busy")
	`AST_IMPLY(a_edit_no_field, clk, arst_n, done && (status == STAT_FULL || status == STAT_EMPTY), field_x == 0 && field_y == 0 && field_z == 0 && !saturated, "edit transaction carries field data")
	`AST_IMPLY(a_busy_query, clk, arst_n, $rose(busy), $past(start) && $past(command) == CMD_QUERY, "busy raised without a query")
endmodule

bind polyline_wire_field_engine pfe_chk u_pfe_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.command  (command),
	.done     (done),
	.field_x  (field_x),
	.field_y  (field_y),
	.field_z  (field_z),
	.status   (status),
	.saturated(saturated)
);
`default_nettype wire
